/* rtl/core/apm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_pkg
// Shared constants, types and register map of the peak-to-peak level meter.
// ----------------------------------------------------------------------------
package apm_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int MAX_WINDOW   = 1024;
    localparam int LEN_BITS     = 11;
    localparam int FILL_BITS    = 11;
    localparam int OUT_BITS     = 12;
    localparam int SUM_BITS     = 44;
    localparam int COUNT_BITS   = 32;
    localparam int DIV_STEPS    = SUM_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 2;

    // Register indexes, byte address is 4 * index
    localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH   = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_NOISE_FLOOR     = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_THRESHOLD = 2'd2;

    localparam logic [LEN_BITS-1:0]    WINDOW_LENGTH_RST = 11'd64;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX        = {SAMPLE_BITS{1'b1}};

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef struct packed {
        logic sample;
        logic clear;
        logic finish;
        logic div_start;
        logic out_load;
    } t_ctrl;

endpackage

/* rtl/core/apm_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_window
// Min/max tracker over one measurement window and noise-corrected span.
// ----------------------------------------------------------------------------
module apm_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_sample_en,
    input  logic [apm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    input  logic [apm_pkg::LEN_BITS-1:0]  i_window_length,
    input  logic [apm_pkg::SAMPLE_BITS-1:0] i_noise_floor,
    output logic                          o_full,
    output logic [apm_pkg::OUT_BITS-1:0]  o_level
);
    import apm_pkg::*;

    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [FILL_BITS-1:0]   r_fill;
    logic                   r_full;
    logic [FILL_BITS-1:0]   n_fill;
    logic [LEN_BITS-1:0]    eff_len;
    logic [SAMPLE_BITS-1:0] span;

    // Length zero acts as one, anything above the maximum is clipped
    always_comb begin
        if (i_window_length == '0) begin
            eff_len = LEN_BITS'(1);
        end else if (i_window_length > LEN_BITS'(MAX_WINDOW)) begin
            eff_len = LEN_BITS'(MAX_WINDOW);
        end else begin
            eff_len = i_window_length;
        end
    end

    assign n_fill = r_fill + FILL_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= SAMPLE_MAX;
            r_max  <= '0;
            r_fill <= '0;
            r_full <= 1'b0;
        end else if (i_restart) begin
            r_min  <= SAMPLE_MAX;
            r_max  <= '0;
            r_fill <= '0;
            r_full <= 1'b0;
        end else if (i_sample_en) begin
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
            r_fill <= n_fill;
            r_full <= (n_fill >= eff_len);
        end
    end

    always_comb begin
        span    = (r_max >= r_min) ? (r_max - r_min) : '0;
        o_level = (span > i_noise_floor) ? (span - i_noise_floor) : '0;
    end

    assign o_full = r_full;

endmodule

/* rtl/core/apm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_div
// Restoring divider, one quotient bit per cycle; keeps the low result bits.
// ----------------------------------------------------------------------------
module apm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [apm_pkg::SUM_BITS-1:0]   i_dividend,
    input  logic [apm_pkg::COUNT_BITS-1:0] i_divisor,
    output apm_pkg::t_div_status           o_status,
    output logic [apm_pkg::OUT_BITS-1:0]   o_quotient
);
    import apm_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [SUM_BITS-1:0]     r_dvd;
    logic [COUNT_BITS-1:0]   r_dvs;
    logic [COUNT_BITS-1:0]   r_rem;
    logic [OUT_BITS-1:0]     r_quo;
    logic [COUNT_BITS:0]     trial;
    logic [COUNT_BITS:0]     diff;
    logic                    ge;

    always_comb begin
        trial = {r_rem, r_dvd[SUM_BITS-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            // remainder stays below the divisor, so its top bit drops out
            r_rem <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_dvd <= {r_dvd[SUM_BITS-2:0], 1'b0};
            r_quo <= {r_quo[OUT_BITS-2:0], ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;

endmodule

/* rtl/core/audio_peak_to_peak_level_meter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_peak_to_peak_level_meter_core
// Windowed peak-to-peak level meter with held peak and running mean.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries a mode bit and a 12-bit
// ADC sample. Mode clear zeroes peak, sum and count in the accept cycle and
// gives no result. A sample that does not end its window goes idle after the check.
// A sample that ends the window produces one output transaction
// (o_out_valid / i_out_stall) with level, held peak, mean and loudness flag.
// That item passes through the level and accumulator update, the divider
// start, the mean, which runs through one shared subtract-and-compare unit
// one quotient bit per cycle and then signals done, and the load of the
// output register. One item is in flight at a time; o_in_stall is high
// while it is worked on. The output register holds its payload while
// i_out_stall is high; a new result waits in the last step until the
// register is free.
// Reset (i_rst_n, synchronous, active low) restores register defaults,
// empties the window, clears peak, sum and count and drops any result.
// Configuration is an APB-style port, registers at byte addresses 0, 4, 8.
// ----------------------------------------------------------------------------
module audio_peak_to_peak_level_meter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [apm_pkg::SAMPLE_BITS-1:0]   i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [apm_pkg::OUT_BITS-1:0]      o_level,
    output logic [apm_pkg::OUT_BITS-1:0]      o_peak,
    output logic [apm_pkg::OUT_BITS-1:0]      o_average,
    output logic                              o_above_threshold,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [apm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [apm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [apm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import apm_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    t_ctrl                  ctrl;
    t_div_status            div_stat;

    logic [LEN_BITS-1:0]    r_window_length;
    logic [SAMPLE_BITS-1:0] r_noise_floor;
    logic [SAMPLE_BITS-1:0] r_level_threshold;

    logic [OUT_BITS-1:0]    r_peak;
    logic [SUM_BITS-1:0]    r_sum;
    logic [COUNT_BITS-1:0]  r_count;
    logic [OUT_BITS-1:0]    r_level;

    logic                   r_out_valid;
    logic [OUT_BITS-1:0]    r_out_level;
    logic [OUT_BITS-1:0]    r_out_peak;
    logic [OUT_BITS-1:0]    r_out_average;
    logic                   r_out_above;

    logic                   in_accept;
    logic                   out_free;
    logic                   cfg_write;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                   win_full;
    logic [OUT_BITS-1:0]    win_level;
    logic [OUT_BITS-1:0]    quotient;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length   <= WINDOW_LENGTH_RST;
            r_noise_floor     <= '0;
            r_level_threshold <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_WINDOW_LENGTH:   r_window_length   <= pwdata[LEN_BITS-1:0];
                REG_NOISE_FLOOR:     r_noise_floor     <= pwdata[SAMPLE_BITS-1:0];
                REG_LEVEL_THRESHOLD: r_level_threshold <= pwdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WINDOW_LENGTH:   prdata = APB_DATA_BITS'(r_window_length);
            REG_NOISE_FLOOR:     prdata = APB_DATA_BITS'(r_noise_floor);
            REG_LEVEL_THRESHOLD: prdata = APB_DATA_BITS'(r_level_threshold);
            default:             prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_mode == MODE_SAMPLE)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = win_full ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (r_state)
            S_IDLE: begin
                ctrl.sample = in_accept && (i_mode == MODE_SAMPLE);
                ctrl.clear  = in_accept && (i_mode == MODE_CLEAR);
            end
            S_CHECK: begin
                ctrl.finish = win_full;
            end
            S_LOAD: begin
                ctrl.div_start = 1'b1;
            end
            S_EMIT: begin
                ctrl.out_load = out_free;
            end
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- window tracker and divider ----------------
    apm_window u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample_en     (ctrl.sample),
        .i_sample        (i_sample),
        .i_restart       (ctrl.finish),
        .i_window_length (r_window_length),
        .i_noise_floor   (r_noise_floor),
        .o_full          (win_full),
        .o_level         (win_level)
    );

    apm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_status   (div_stat),
        .o_quotient (quotient)
    );

    // ---------------- peak and running accumulators ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (ctrl.clear) begin
            r_peak  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else if (ctrl.finish) begin
            if (win_level > r_peak) begin
                r_peak <= win_level;
            end
            // freeze sum and count once the count saturates
            if (r_count != {COUNT_BITS{1'b1}}) begin
                r_sum   <= r_sum + SUM_BITS'(win_level);
                r_count <= r_count + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.finish) begin
            r_level <= win_level;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_level   <= r_level;
            r_out_peak    <= r_peak;
            r_out_average <= quotient;
            r_out_above   <= (r_level > r_level_threshold);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_level           = r_out_level;
    assign o_peak            = r_out_peak;
    assign o_average         = r_out_average;
    assign o_above_threshold = r_out_above;

    // ---------------- assertions ----------------
    a_valid_from_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EMIT))
        else $error("result raised outside the emit step");

    a_div_done_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_stat.busy || div_stat.done) |-> (r_state == S_DIV))
        else $error("divider active outside the divide step");

    a_count_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_count != '0))
        else $error("mean started with an empty window count");

    a_peak_holds_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |-> (r_peak >= r_level))
        else $error("held peak below the current level");

endmodule

/* tb/apm_meter_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apm_meter_check
// Result predictor and comparator for the peak-to-peak level meter.
// ----------------------------------------------------------------------------
// Watches the sample channel, the result channel and the register port.
// Each accepted sample goes through a local model of the window min/max,
// held peak, running sum and window count; a finished window queues the
// result it should produce. Each accepted result is compared field by field
// against the oldest queued one. Failures, pending results and compared
// results are reported to the testbench top.
// ----------------------------------------------------------------------------
module apm_meter_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_mode,
    input  logic [apm_pkg::SAMPLE_BITS-1:0]   i_sample,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [apm_pkg::OUT_BITS-1:0]      i_level,
    input  logic [apm_pkg::OUT_BITS-1:0]      i_peak,
    input  logic [apm_pkg::OUT_BITS-1:0]      i_average,
    input  logic                              i_above_threshold,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic                              i_pready,
    input  logic [apm_pkg::APB_ADDR_BITS-1:0] i_paddr,
    input  logic [apm_pkg::APB_DATA_BITS-1:0] i_pwdata,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    import apm_pkg::*;

    typedef struct packed {
        logic [OUT_BITS-1:0] level;
        logic [OUT_BITS-1:0] peak;
        logic [OUT_BITS-1:0] average;
        logic                above;
    } t_level_result;

    t_level_result level_expect_q[$];

    // register copies
    logic [LEN_BITS-1:0]    cfg_length;
    logic [SAMPLE_BITS-1:0] cfg_floor;
    logic [SAMPLE_BITS-1:0] cfg_threshold;

    // meter state
    logic [SAMPLE_BITS-1:0] win_lo;
    logic [SAMPLE_BITS-1:0] win_hi;
    logic [FILL_BITS-1:0]   win_fill;
    logic [OUT_BITS-1:0]    held_peak;
    logic [SUM_BITS-1:0]    level_total;
    logic [COUNT_BITS-1:0]  window_total;

    int fail_tally;
    int checked_tally;

    function automatic logic [LEN_BITS-1:0] active_length(input logic [LEN_BITS-1:0] len);
        if (len == '0) begin
            return LEN_BITS'(1);
        end
        if (len > LEN_BITS'(MAX_WINDOW)) begin
            return LEN_BITS'(MAX_WINDOW);
        end
        return len;
    endfunction

    task automatic take_sample(input logic [SAMPLE_BITS-1:0] smp);
        logic [SAMPLE_BITS-1:0] span;
        logic [OUT_BITS-1:0]    lvl;
        t_level_result          res;
        if (smp < win_lo) begin
            win_lo = smp;
        end
        if (smp > win_hi) begin
            win_hi = smp;
        end
        win_fill = win_fill + 1'b1;
        if (win_fill < active_length(cfg_length)) begin
            return;
        end
        span = (win_hi >= win_lo) ? win_hi - win_lo : '0;
        lvl  = (span > cfg_floor) ? span - cfg_floor : '0;
        win_lo   = SAMPLE_MAX;
        win_hi   = '0;
        win_fill = '0;
        if (lvl > held_peak) begin
            held_peak = lvl;
        end
        // freeze sum and count once the count is saturated
        if (window_total != '1) begin
            level_total  = level_total + SUM_BITS'(lvl);
            window_total = window_total + 1'b1;
        end
        res.level   = lvl;
        res.peak    = held_peak;
        res.average = (window_total != '0) ? OUT_BITS'(level_total / window_total) : '0;
        res.above   = (lvl > cfg_threshold);
        level_expect_q.push_back(res);
    endtask

    task automatic compare_result();
        t_level_result want;
        if (level_expect_q.size() == 0) begin
            $error("unexpected result: level %0d peak %0d average %0d flag %0d",
                   i_level, i_peak, i_average, i_above_threshold);
            fail_tally++;
            return;
        end
        want = level_expect_q.pop_front();
        checked_tally++;
        if (i_level !== want.level) begin
            $error("level mismatch: expected %0d, got %0d", want.level, i_level);
            fail_tally++;
        end
        if (i_peak !== want.peak) begin
            $error("peak mismatch: expected %0d, got %0d", want.peak, i_peak);
            fail_tally++;
        end
        if (i_average !== want.average) begin
            $error("average mismatch: expected %0d, got %0d", want.average, i_average);
            fail_tally++;
        end
        if (i_above_threshold !== want.above) begin
            $error("above_threshold mismatch: expected %0d, got %0d",
                   want.above, i_above_threshold);
            fail_tally++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_length    = WINDOW_LENGTH_RST;
            cfg_floor     = '0;
            cfg_threshold = '0;
            win_lo        = SAMPLE_MAX;
            win_hi        = '0;
            win_fill      = '0;
            held_peak     = '0;
            level_total   = '0;
            window_total  = '0;
            fail_tally    = 0;
            checked_tally = 0;
            level_expect_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_result();
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_mode == MODE_CLEAR) begin
                    // window being gathered is left alone
                    held_peak    = '0;
                    level_total  = '0;
                    window_total = '0;
                end else begin
                    take_sample(i_sample);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_BITS-1:2])
                    REG_WINDOW_LENGTH: begin
                        cfg_length = i_pwdata[LEN_BITS-1:0];
                    end
                    REG_NOISE_FLOOR: begin
                        cfg_floor = i_pwdata[SAMPLE_BITS-1:0];
                    end
                    REG_LEVEL_THRESHOLD: begin
                        cfg_threshold = i_pwdata[SAMPLE_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= level_expect_q.size();
        o_checked    <= checked_tally;
    end

endmodule

/* tb/audio_peak_to_peak_level_meter_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_peak_to_peak_level_meter_core_tb
// Self-checking testbench for the peak-to-peak level meter core.
// ----------------------------------------------------------------------------
// Drives samples and clears in random bursts while the result side stalls
// on its own pattern, including one long hold-off that backs the block up.
// A short directed sequence covers full-scale spans, noise floor and
// threshold boundaries, window length zero and a window shortened below its
// fill; random phases then sweep window length, noise floor and threshold.
// Checking is done by apm_meter_check; this module gives the verdict.
// ----------------------------------------------------------------------------
module audio_peak_to_peak_level_meter_core_tb;
    import apm_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_mode   = MODE_SAMPLE;
    logic [SAMPLE_BITS-1:0]   in_sample = '0;
    logic                     out_stall = 1'b0;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr     = '0;
    logic [APB_DATA_BITS-1:0] pwdata    = '0;

    logic                     in_stall;
    logic                     out_valid;
    logic [OUT_BITS-1:0]      level;
    logic [OUT_BITS-1:0]      peak;
    logic [OUT_BITS-1:0]      average;
    logic                     above_threshold;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int fail_count;
    int pending;
    int checked;
    int items_sent   = 0;
    int burst_left   = 0;
    int cfg_settings = 0;
    int cycle_count  = 0;
    bit start_hold   = 1'b0;

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    audio_peak_to_peak_level_meter_core dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_mode            (in_mode),
        .i_sample          (in_sample),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_level           (level),
        .o_peak            (peak),
        .o_average         (average),
        .o_above_threshold (above_threshold),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    apm_meter_check level_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_mode            (in_mode),
        .i_sample          (in_sample),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_level           (level),
        .i_peak            (peak),
        .i_average         (average),
        .i_above_threshold (above_threshold),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    // Offer one transaction, opening a random gap between bursts.
    task automatic offer(input logic mode, input logic [SAMPLE_BITS-1:0] smp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            case ($urandom_range(19, 0))
                0, 1, 2, 3, 4:  gap = 0;
                5:              gap = $urandom_range(120, 41);
                6, 7:           gap = $urandom_range(40, 7);
                default:        gap = $urandom_range(6, 1);
            endcase
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        in_mode   <= mode;
        in_sample <= smp;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Drop valid, wait out every pending result, then let the block go idle.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // pause with the bus idle before the next transfer
        @(posedge clk);
    endtask

    task automatic program_meter(input int len, input int floor_val, input int thr);
        settle();
        write_reg(REG_WINDOW_LENGTH, len);
        write_reg(REG_NOISE_FLOOR, floor_val);
        write_reg(REG_LEVEL_THRESHOLD, thr);
        cfg_settings++;
    endtask

    function automatic int pick_length();
        case ($urandom_range(9, 0))
            0:          return 0;
            1:          return 1;
            2, 3, 4, 5: return $urandom_range(8, 2);
            6, 7:       return $urandom_range(64, 9);
            8:          return MAX_WINDOW;
            default:    return $urandom_range(2047, MAX_WINDOW + 1);
        endcase
    endfunction

    function automatic int pick_floor();
        case ($urandom_range(19, 0))
            0:                 return 4095;
            1, 2, 3, 4, 5, 6:  return 0;
            7, 8, 9, 10:       return $urandom_range(4095, 0);
            default:           return $urandom_range(300, 0);
        endcase
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(9, 0))
            0:       return 0;
            1:       return 4095;
            2, 3:    return $urandom_range(4095, 0);
            default: return $urandom_range(600, 0);
        endcase
    endfunction

    // Mix full-range readings, rail values and a cluster around a centre.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int centre, input int spread);
        int v;
        case ($urandom_range(9, 0))
            0:          v = $urandom_range(1, 0) ? 4095 : 0;
            1, 2, 3, 4: v = $urandom_range(4095, 0);
            default:    v = centre - spread + $urandom_range(2 * spread, 0);
        endcase
        if (v < 0) begin
            v = 0;
        end
        if (v > 4095) begin
            v = 4095;
        end
        return SAMPLE_BITS'(v);
    endfunction

    // Result side: stall segments of varying density, one long hold-off.
    initial begin : result_side
        int seg;
        int style;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            seg   = $urandom_range(200, 20);
            style = $urandom_range(3, 0);
            if (start_hold && !hold_done) begin
                hold_done = 1'b1;
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            repeat (seg) begin
                @(posedge clk);
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(3, 0) == 0);
                    2:       out_stall <= ($urandom_range(3, 0) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $error("no completion after %0d cycles", CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int centre;
        int spread;
        int count;
        int len;
        int rphase;
        int random_start;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset window length still in force: these only gather
        offer(MODE_CLEAR, 12'hFFF);
        offer(MODE_SAMPLE, 12'd0);
        offer(MODE_SAMPLE, 12'hFFF);
        offer(MODE_SAMPLE, 12'd2048);
        // shorten the window below its fill: the next sample closes it
        settle();
        write_reg(REG_WINDOW_LENGTH, 2);
        cfg_settings++;
        offer(MODE_SAMPLE, 12'd100);
        offer(MODE_SAMPLE, 12'd7);
        offer(MODE_SAMPLE, 12'd7);
        offer(MODE_CLEAR, 12'd0);
        offer(MODE_SAMPLE, 12'hFFF);
        offer(MODE_SAMPLE, 12'd0);
        // floor swallows a full-scale span
        program_meter(2, 4095, 4095);
        offer(MODE_SAMPLE, 12'd0);
        offer(MODE_SAMPLE, 12'hFFF);
        // level one above and exactly at the threshold
        program_meter(2, 0, 4094);
        offer(MODE_SAMPLE, 12'd0);
        offer(MODE_SAMPLE, 12'hFFF);
        program_meter(2, 1, 4094);
        offer(MODE_SAMPLE, 12'hFFF);
        offer(MODE_SAMPLE, 12'd0);
        // zero length acts as one
        program_meter(0, 0, 0);
        offer(MODE_SAMPLE, 12'd1234);
        offer(MODE_SAMPLE, 12'hFFF);
        program_meter(1, 0, 0);
        offer(MODE_SAMPLE, 12'd0);

        rphase       = 0;
        random_start = items_sent;
        start_hold   = 1'b1;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            centre = $urandom_range(4095, 0);
            spread = $urandom_range(400, 0);
            if (rphase == 0) begin
                // short windows keep the sender busy through the hold-off
                program_meter($urandom_range(4, 1), 0, $urandom_range(600, 0));
                count = 150;
            end else if (rphase == 3) begin
                // oversized length must clamp to the largest window
                program_meter(2047, pick_floor(), pick_threshold());
                count = MAX_WINDOW;
            end else begin
                len = pick_length();
                program_meter(len, pick_floor(), pick_threshold());
                count = (len > 64) ? $urandom_range(60, 20) : $urandom_range(120, 30);
            end
            repeat (count) begin
                if ($urandom_range(31, 0) == 0) begin
                    offer(MODE_CLEAR, SAMPLE_BITS'($urandom_range(4095, 0)));
                end else begin
                    offer(MODE_SAMPLE, pick_sample(centre, spread));
                end
            end
            rphase++;
        end
        settle();

        $display("Run: %0d sample and clear transactions over %0d register settings.",
                 items_sent, cfg_settings);
        $display("Run: %0d window results compared, %0d failures.", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/apm_pkg.sv
rtl/core/apm_window.sv
rtl/core/apm_div.sv
rtl/core/audio_peak_to_peak_level_meter_core.sv
tb/apm_meter_check.sv
tb/audio_peak_to_peak_level_meter_core_tb.sv
